// ===== rtl/ppp_pkg.sv =====
// ppp_pkg: constants, payload types and helpers for the pinhole point projection.
// Used by every module of the block; depends on nothing.
package ppp_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int COEFF_WIDTH = 32;
    localparam int PT_W        = 32;
    localparam int PROD_W      = COEFF_WIDTH + PT_W;
    localparam int SHIFT_W     = PROD_W - FRAC_BITS;
    localparam int SUM_W       = SHIFT_W + 2;
    localparam int QB          = 32;
    localparam int DIV_W       = SUM_W + QB;
    localparam int NUM_REGS    = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_W       = 64;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam logic [QB-1:0] MAX_POS = {1'b0, {(QB-1){1'b1}}};
    localparam logic [QB-1:0] MIN_NEG = {1'b1, {(QB-1){1'b0}}};

    typedef struct packed {
        logic signed [PT_W-1:0] point_x;
        logic signed [PT_W-1:0] point_y;
        logic signed [PT_W-1:0] point_z;
    } t_point;

    typedef struct packed {
        logic signed [QB-1:0] image_u;
        logic signed [QB-1:0] image_v;
        logic [1:0]           status;
    } t_image;

    typedef struct packed {
        logic signed [SUM_W-1:0] s0;
        logic signed [SUM_W-1:0] s1;
        logic signed [SUM_W-1:0] s2;
    } t_sums;

    typedef logic [NUM_REGS-1:0][CFG_W-1:0] t_cfg_regs;

    function automatic logic signed [COEFF_WIDTH-1:0] coeff(t_cfg_regs r, int row, int col);
        logic [CFG_W-1:0] w;
        logic [31:0]      half;
        w    = r[row * 2 + (col >> 1)];
        half = col[0] ? w[63:32] : w[31:0];
        return half[COEFF_WIDTH-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] abs_sum(logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] ng;
        ng = -s;
        return s[SUM_W-1] ? unsigned'(ng) : unsigned'(s);
    endfunction

endpackage

// ===== rtl/pinhole_point_projection_top.sv =====
// pinhole_point_projection_top: configuration registers, row sums and divider pipeline.
// Depends on ppp_pkg, ppp_rows and ppp_divider.
//
//   channel | valid       | ready        | payload
//   cfg     | i_cfg_valid | o_cfg_ready  | i_cfg_index, i_cfg_data
//   in      | i_in_valid  | o_in_ready   | i_in   (t_point)
//   out     | o_out_valid | i_out_ready  | o_out  (t_image)
//
// One point per cycle while the output is not stalled; pipeline registers are two row stages, sign split,
// one stage per quotient bit, saturation/output register.
// Every stage has its own valid bit and moves when the stage after it is free,
// so a stalled output holds its beat and bubbles still fill.
// Synchronous active-low reset loads the identity-like default matrix.
module pinhole_point_projection_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ppp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ppp_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  ppp_pkg::t_point                 i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output ppp_pkg::t_image                 o_out
);
    ppp_pkg::t_cfg_regs r_cfg;
    ppp_pkg::t_sums     sums;
    logic               sums_valid, sums_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[0] <= 64'h0000_0000_0001_0000;
            r_cfg[1] <= '0;
            r_cfg[2] <= 64'h0001_0000_0000_0000;
            r_cfg[3] <= '0;
            r_cfg[4] <= '0;
            r_cfg[5] <= 64'h0000_0000_0001_0000;
        end else if (i_cfg_valid) begin
            for (int i = 0; i < ppp_pkg::NUM_REGS; i++) begin
                if (i_cfg_index == ppp_pkg::CFG_IDX_W'(i)) r_cfg[i] <= i_cfg_data;
            end
        end
    end

    ppp_rows u_rows (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_point (i_in),
        .o_valid (sums_valid),
        .i_ready (sums_ready),
        .o_sums  (sums)
    );

    ppp_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sums_valid),
        .o_ready (sums_ready),
        .i_sums  (sums),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_image (o_out)
    );
endmodule

// ===== rtl/ppp_rows.sv =====
// ppp_rows: two pipeline stages, nine coefficient products, then the three row sums.
// Depends on ppp_pkg.
module ppp_rows (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ppp_pkg::t_cfg_regs i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  ppp_pkg::t_point   i_point,
    output logic              o_valid,
    input  logic              i_ready,
    output ppp_pkg::t_sums    o_sums
);
    logic signed [ppp_pkg::PROD_W-1:0]      r_p [3][3];
    logic signed [ppp_pkg::COEFF_WIDTH-1:0] r_c [3];
    logic signed [ppp_pkg::PROD_W-1:0]      n_p [3][3];
    logic signed [ppp_pkg::PT_W-1:0]        pt [3];
    logic signed [ppp_pkg::SUM_W-1:0]       n_s [3];
    logic r_v1, r_v2, rdy1, rdy2;
    ppp_pkg::t_sums r_sums;

    assign rdy2    = !r_v2 || i_ready;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v2;
    assign o_sums  = r_sums;

    assign pt[0] = i_point.point_x;
    assign pt[1] = i_point.point_y;
    assign pt[2] = i_point.point_z;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_p[r][c] = ppp_pkg::coeff(i_cfg, r, c) * pt[c];
            end
            n_s[r] = ppp_pkg::SUM_W'(r_c[r])
                   + ppp_pkg::SUM_W'(r_p[r][0] >>> ppp_pkg::FRAC_BITS)
                   + ppp_pkg::SUM_W'(r_p[r][1] >>> ppp_pkg::FRAC_BITS)
                   + ppp_pkg::SUM_W'(r_p[r][2] >>> ppp_pkg::FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
        end
        if (rdy1 && i_valid) begin
            r_p <= n_p;
            for (int r = 0; r < 3; r++) r_c[r] <= ppp_pkg::coeff(i_cfg, r, 3);
        end
        if (rdy2 && r_v1) begin
            r_sums.s0 <= n_s[0];
            r_sums.s1 <= n_s[1];
            r_sums.s2 <= n_s[2];
        end
    end
endmodule

// ===== rtl/ppp_divider.sv =====
// ppp_divider: sign split, one quotient bit per stage for u and v, then saturation.
// Depends on ppp_pkg.
module ppp_divider (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  ppp_pkg::t_sums  i_sums,
    output logic            o_valid,
    input  logic            i_ready,
    output ppp_pkg::t_image o_image
);
    typedef struct packed {
        logic [ppp_pkg::DIV_W-1:0] rem_u;
        logic [ppp_pkg::DIV_W-1:0] rem_v;
        logic [ppp_pkg::SUM_W-1:0] den;
        logic [ppp_pkg::QB-1:0]    q_u;
        logic [ppp_pkg::QB-1:0]    q_v;
        logic neg_u, neg_v, psat_u, psat_v, zero;
    } t_div_st;

    localparam int NS = ppp_pkg::QB + 1;

    t_div_st r_st [NS];
    t_div_st n_st [NS];
    logic    r_vld [NS];
    logic    rdy [NS+1];
    logic          r_ov;
    ppp_pkg::t_image r_img, n_img;

    assign rdy[NS]  = !r_ov || i_ready;
    assign o_ready  = rdy[0];
    assign o_valid  = r_ov;
    assign o_image  = r_img;

    always_comb begin
        logic [ppp_pkg::SUM_W-1:0] au, av;
        logic [ppp_pkg::DIV_W-1:0] lim;
        au = ppp_pkg::abs_sum(i_sums.s0);
        av = ppp_pkg::abs_sum(i_sums.s1);
        n_st[0].den    = ppp_pkg::abs_sum(i_sums.s2);
        n_st[0].neg_u  = i_sums.s0[ppp_pkg::SUM_W-1] ^ i_sums.s2[ppp_pkg::SUM_W-1];
        n_st[0].neg_v  = i_sums.s1[ppp_pkg::SUM_W-1] ^ i_sums.s2[ppp_pkg::SUM_W-1];
        n_st[0].zero   = (i_sums.s2 == '0);
        n_st[0].rem_u  = ppp_pkg::DIV_W'(au) << ppp_pkg::FRAC_BITS;
        n_st[0].rem_v  = ppp_pkg::DIV_W'(av) << ppp_pkg::FRAC_BITS;
        lim            = ppp_pkg::DIV_W'(n_st[0].den) << (ppp_pkg::QB - ppp_pkg::FRAC_BITS);
        n_st[0].psat_u = ppp_pkg::DIV_W'(au) >= lim;
        n_st[0].psat_v = ppp_pkg::DIV_W'(av) >= lim;
        n_st[0].q_u    = '0;
        n_st[0].q_v    = '0;
    end

    for (genvar k = 1; k < NS; k++) begin : g_step
        localparam int B = ppp_pkg::QB - k;
        logic [ppp_pkg::DIV_W-1:0] dsh;
        assign dsh = ppp_pkg::DIV_W'(r_st[k-1].den) << B;
        always_comb begin
            n_st[k] = r_st[k-1];
            if (r_st[k-1].rem_u >= dsh) begin
                n_st[k].rem_u  = r_st[k-1].rem_u - dsh;
                n_st[k].q_u[B] = 1'b1;
            end
            if (r_st[k-1].rem_v >= dsh) begin
                n_st[k].rem_v  = r_st[k-1].rem_v - dsh;
                n_st[k].q_v[B] = 1'b1;
            end
        end
    end

    always_comb begin
        t_div_st s;
        logic sat_u, sat_v;
        logic [ppp_pkg::QB-1:0] u, v;
        s = r_st[NS-1];
        sat_u = s.psat_u || (s.neg_u ? (s.q_u > ppp_pkg::MIN_NEG) : (s.q_u > ppp_pkg::MAX_POS));
        sat_v = s.psat_v || (s.neg_v ? (s.q_v > ppp_pkg::MIN_NEG) : (s.q_v > ppp_pkg::MAX_POS));
        if (sat_u) u = s.neg_u ? ppp_pkg::MIN_NEG : ppp_pkg::MAX_POS;
        else       u = s.neg_u ? (~s.q_u + 1'b1) : s.q_u;
        if (sat_v) v = s.neg_v ? ppp_pkg::MIN_NEG : ppp_pkg::MAX_POS;
        else       v = s.neg_v ? (~s.q_v + 1'b1) : s.q_v;
        if (s.zero) begin
            n_img.image_u = '0;
            n_img.image_v = '0;
            n_img.status  = ppp_pkg::ST_ZERO;
        end else begin
            n_img.image_u = u;
            n_img.image_v = v;
            n_img.status  = (sat_u || sat_v) ? ppp_pkg::ST_SAT : ppp_pkg::ST_OK;
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_reg
        assign rdy[k] = !r_vld[k] || rdy[k+1];
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (rdy[k]) begin
                    r_vld[k] <= i_valid;
                end
                if (rdy[k] && i_valid) r_st[k] <= n_st[k];
            end
        end else begin : g_rest
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
                if (rdy[k] && r_vld[k-1]) r_st[k] <= n_st[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (rdy[NS]) begin
            r_ov <= r_vld[NS-1];
        end
        if (rdy[NS] && r_vld[NS-1]) r_img <= n_img;
    end
endmodule
